// ===== hdl/wcsf_pkg.sv =====
// Shared types, status codes and constants of the WebAssembly custom section finder.
package wcsf_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int STATUS_W    = 3;
    localparam int FIELD_W     = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SECTION_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_NAME_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_NAME_LOW    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_NAME_HIGH   = 2'd3;

    localparam logic [31:0] MAX_SECTION_SIZE_RESET = 32'd1048576;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [31:0]  max_size;
        logic [4:0]   target_len;
        logic [127:0] name;       // byte 0 in bits 7..0, byte 15 in bits 127..120
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  data_offset;
        logic [FIELD_W-1:0]  data_length;
    } t_result;

    // Eight-byte magic and version that open every image.
    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd1:    b = 8'h61;
            3'd2:    b = 8'h73;
            3'd3:    b = 8'h6d;
            3'd4:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/wcsf_byte_if.sv =====
// Stream channel that carries one image byte per word.
interface wcsf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       is_last;

    modport source (output valid, output image_byte, output is_last, input ready);
    modport sink   (input valid, input image_byte, input is_last, output ready);
endinterface

// ===== hdl/wcsf_result_if.sv =====
// Result channel that carries one search outcome per word.
interface wcsf_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] data_offset;
    logic [31:0] data_length;

    modport source (output valid, output status, output data_offset, output data_length,
                    input ready);
    modport sink   (input valid, input status, input data_offset, input data_length,
                    output ready);
endinterface

// ===== hdl/wcsf_cfg_regs.sv =====
// Configuration register file written through the plain write port.
module wcsf_cfg_regs
    import wcsf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_size   <= MAX_SECTION_SIZE_RESET;
            r_cfg.target_len <= '0;
            r_cfg.name       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_SECTION_SIZE:   r_cfg.max_size     <= i_cfg_data[31:0];
                CFG_TARGET_NAME_LENGTH: r_cfg.target_len   <= i_cfg_data[4:0];
                CFG_TARGET_NAME_LOW:    r_cfg.name[63:0]   <= i_cfg_data;
                CFG_TARGET_NAME_HIGH:   r_cfg.name[127:64] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/wcsf_parser.sv =====
// Section walker: parse state and the single-byte update that yields at most one result.
module wcsf_parser
    import wcsf_pkg::*;
#(
    parameter int NAME_MAX    = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic [7:0] i_byte,
    input  logic    i_last,
    input  t_cfg    i_cfg,
    output logic    o_hit,
    output t_result o_result
);

    localparam int SUM_W = ((OFFSET_BITS + 1 > 32) ? OFFSET_BITS + 1 : 32) + 1;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [4:0] NAME_MAX_W = 5'(NAME_MAX);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SEC_ID,
        PH_SEC_LEN,
        PH_NAME_LEN,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    t_phase                 r_phase,      n_phase;
    logic [OFFSET_BITS-1:0] r_offset,     n_offset;
    logic [31:0]            r_acc,        n_acc;
    logic [2:0]             r_cnt,        n_cnt;
    logic                   r_custom,     n_custom;
    logic [OFFSET_BITS-1:0] r_sec_end,    n_sec_end;
    logic [4:0]             r_pos,        n_pos;
    logic                   r_eq,         n_eq;
    logic [OFFSET_BITS-1:0] r_data_start, n_data_start;

    logic [OFFSET_BITS:0]   w_next;
    logic [4:0]             w_shift;
    logic [38:0]            w_part;
    logic [31:0]            w_acc_new;
    logic                   w_leb_done;
    logic                   w_leb_long;
    logic [SUM_W-1:0]       w_sum;
    logic                   w_cmp;
    logic [7:0]             w_tbyte;
    logic                   w_hit;
    t_result                w_res;

    always_comb begin
        n_phase      = r_phase;
        n_offset     = r_offset;
        n_acc        = r_acc;
        n_cnt        = r_cnt;
        n_custom     = r_custom;
        n_sec_end    = r_sec_end;
        n_pos        = r_pos;
        n_eq         = r_eq;
        n_data_start = r_data_start;
        w_hit        = 1'b0;
        w_res        = '0;
        w_res.status = ST_FOUND;

        w_next     = {1'b0, r_offset} + {{OFFSET_BITS{1'b0}}, 1'b1};
        w_shift    = {2'b00, r_cnt} * 5'd7;
        w_part     = 39'(i_byte[6:0]) << w_shift;
        w_acc_new  = r_acc | w_part[31:0];
        w_leb_done = !i_byte[7];
        w_leb_long = i_byte[7] && (r_cnt == 3'd4);
        w_sum      = SUM_W'(w_next) + SUM_W'(w_acc_new);
        w_cmp      = r_custom && r_eq && (r_pos < i_cfg.target_len) && (r_pos < NAME_MAX_W);
        w_tbyte    = i_cfg.name[{r_pos[3:0], 3'b000} +: 8];

        case (r_phase)
            PH_HEADER: begin
                if (i_byte != header_byte(r_offset[2:0])) begin
                    w_hit        = 1'b1;
                    w_res.status = ST_INVALID;
                    n_phase      = PH_DONE;
                end else if (r_offset >= OFFSET_BITS'(7)) begin
                    n_phase = PH_SEC_ID;
                end
            end
            PH_SEC_ID: begin
                n_custom = (i_byte == 8'h00);
                n_acc    = '0;
                n_cnt    = '0;
                n_phase  = PH_SEC_LEN;
            end
            PH_SEC_LEN: begin
                if (w_leb_long) begin
                    w_hit        = 1'b1;
                    w_res.status = ST_TRUNC;
                    n_phase      = PH_DONE;
                end else if (w_leb_done) begin
                    if (w_acc_new > i_cfg.max_size || w_sum > SUM_W'(OFFSET_MAX)) begin
                        w_hit        = 1'b1;
                        w_res.status = ST_OVERFLOW;
                        n_phase      = PH_DONE;
                    end else begin
                        n_sec_end = OFFSET_BITS'(w_sum);
                        n_acc     = '0;
                        n_cnt     = '0;
                        if (r_custom) begin
                            n_phase = PH_NAME_LEN;
                        end else if (w_acc_new == '0) begin
                            n_phase = PH_SEC_ID;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end else begin
                    n_acc = w_acc_new;
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_NAME_LEN: begin
                if (w_leb_long) begin
                    w_hit        = 1'b1;
                    w_res.status = ST_TRUNC;
                    n_phase      = PH_DONE;
                end else if (w_leb_done) begin
                    // The name must fit inside the section it belongs to.
                    if (w_sum > SUM_W'(r_sec_end)) begin
                        w_hit        = 1'b1;
                        w_res.status = ST_TRUNC;
                        n_phase      = PH_DONE;
                    end else begin
                        n_eq = (i_cfg.target_len <= NAME_MAX_W) &&
                               (w_acc_new == 32'(i_cfg.target_len));
                        n_pos        = '0;
                        n_data_start = OFFSET_BITS'(w_sum);
                        if (w_next == {1'b0, r_sec_end}) begin
                            if (n_eq) begin
                                w_hit             = 1'b1;
                                w_res.data_offset = 32'(n_data_start);
                                w_res.data_length = 32'(r_sec_end - n_data_start);
                                n_phase           = PH_DONE;
                            end else begin
                                n_phase = PH_SEC_ID;
                            end
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end else begin
                    n_acc = w_acc_new;
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                if (w_cmp) begin
                    if (i_byte != w_tbyte) begin
                        n_eq = 1'b0;
                    end
                    n_pos = r_pos + 5'd1;
                end
                if (w_next == {1'b0, r_sec_end}) begin
                    if (r_custom && n_eq) begin
                        w_hit             = 1'b1;
                        w_res.data_offset = 32'(r_data_start);
                        w_res.data_length = 32'(r_sec_end - r_data_start);
                        n_phase           = PH_DONE;
                    end else begin
                        n_phase = PH_SEC_ID;
                    end
                end
            end
            default: ;
        endcase

        // End of stream and offset range checks, when this byte gave no outcome.
        if (!w_hit && n_phase != PH_DONE) begin
            if (i_last) begin
                w_hit = 1'b1;
                if (n_phase == PH_SEC_ID) begin
                    w_res.status = ST_NOTFOUND;
                end else if (n_phase == PH_HEADER) begin
                    w_res.status = ST_INVALID;
                end else begin
                    w_res.status = ST_TRUNC;
                end
                n_phase = PH_DONE;
            end else if (r_offset == OFFSET_MAX) begin
                w_hit        = 1'b1;
                w_res.status = ST_OVERFLOW;
                n_phase      = PH_DONE;
            end
        end

        if (i_last) begin
            n_phase      = PH_HEADER;
            n_offset     = '0;
            n_acc        = '0;
            n_cnt        = '0;
            n_custom     = 1'b0;
            n_sec_end    = '0;
            n_pos        = '0;
            n_eq         = 1'b0;
            n_data_start = '0;
        end else if (r_offset != OFFSET_MAX) begin
            n_offset = r_offset + OFFSET_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_offset     <= '0;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_custom     <= 1'b0;
            r_sec_end    <= '0;
            r_pos        <= '0;
            r_eq         <= 1'b0;
            r_data_start <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_offset     <= n_offset;
            r_acc        <= n_acc;
            r_cnt        <= n_cnt;
            r_custom     <= n_custom;
            r_sec_end    <= n_sec_end;
            r_pos        <= n_pos;
            r_eq         <= n_eq;
            r_data_start <= n_data_start;
        end
    end

    assign o_hit    = w_hit;
    assign o_result = w_res;

endmodule

// ===== hdl/wasm_custom_section_finder.sv =====
// Top level of the WebAssembly custom section finder: byte stage, parser and result register.
// The block takes one image byte per cycle and sustains that rate for as long as results are
// taken; each accepted byte is held in the byte stage until the result register can take a
// word, is then applied to the section walker, and a result it causes is written to the output
// register at the end of that same cycle, from which the result word is offered. Every image
// gives exactly one result: found with the data offset and length once the matching custom
// section is complete, or invalid, truncated, overflow or not found. Bytes after a result are
// dropped up to and including the last-marked byte, which restarts the header check.
// Configuration writes take effect on the next byte processed.
module wasm_custom_section_finder
    import wcsf_pkg::*;
#(
    parameter int NAME_MAX    = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    wcsf_byte_if.sink              i_img,
    wcsf_result_if.source          o_res,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg       w_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_advance;
    logic       w_hit;
    t_result    w_result;

    wcsf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    wcsf_parser #(
        .NAME_MAX    (NAME_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (w_cfg),
        .o_hit    (w_hit),
        .o_result (w_result)
    );

    // A held word moves through the parser whenever the result register can take a word.
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_img.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_img.valid && i_img.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance && w_hit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_img.valid && i_img.ready) begin
            r_in_byte <= i_img.image_byte;
            r_in_last <= i_img.is_last;
        end
        if (w_advance && w_hit) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.data_offset = r_out.data_offset;
    assign o_res.data_length = r_out.data_length;

`ifndef SYNTHESIS
    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_FOUND) |->
            (r_out.data_offset == '0 && r_out.data_length == '0))
        else $error("error result carries nonzero offset or length");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status <= ST_NOTFOUND))
        else $error("result status out of range");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input word was lost or changed");

    a_found_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FOUND) |-> (r_out.data_offset >= 32'd11))
        else $error("found result points inside the header");
`endif

endmodule
